FILE: rtl/core/twdr_pkg.sv
package twdr_pkg;

  typedef logic [4:0] op_t;

  localparam op_t OP_IDLE  = 5'd0;
  localparam op_t OP_LOAD  = 5'd1;
  localparam op_t OP_MUL_L = 5'd2;
  localparam op_t OP_MUL_R = 5'd3;
  localparam op_t OP_MUL_F = 5'd4;
  localparam op_t OP_DELTA = 5'd5;
  localparam op_t OP_PREP  = 5'd6;
  localparam op_t OP_DIV   = 5'd7;
  localparam op_t OP_TURN  = 5'd8;
  localparam op_t OP_MUL_S = 5'd9;
  localparam op_t OP_SIDE  = 5'd10;
  localparam op_t OP_FOLD  = 5'd11;
  localparam op_t OP_ROT   = 5'd12;
  localparam op_t OP_FLIP  = 5'd13;
  localparam op_t OP_P1    = 5'd14;
  localparam op_t OP_P2    = 5'd15;
  localparam op_t OP_P3    = 5'd16;
  localparam op_t OP_P4    = 5'd17;
  localparam op_t OP_P5    = 5'd18;
  localparam op_t OP_EMIT  = 5'd19;

  typedef struct packed {
    op_t        op;
    logic [4:0] step;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic        tracking_enable;
    logic [15:0] angle_to_distance;
    logic [20:0] side_wheel_offset;
    logic [20:0] front_wheel_offset;
  } cfg_t;

  localparam logic [1:0] REG_ENABLE = 2'd0;
  localparam logic [1:0] REG_A2D    = 2'd1;
  localparam logic [1:0] REG_SIDE   = 2'd2;
  localparam logic [1:0] REG_FRONT  = 2'd3;

  localparam int DIV_BITS = 49;
  localparam int ATAN_LEN = 24;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [34:0] RAD_TO_BAM  = 35'sd683565276;

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/core/twdr_in_if.sv
interface twdr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_angle;
  logic signed [31:0] right_angle;
  logic signed [31:0] front_angle;
  modport source (output valid, left_angle, right_angle, front_angle, input ready);
  modport sink (input valid, left_angle, right_angle, front_angle, output ready);
endinterface

FILE: rtl/core/twdr_out_if.sv
interface twdr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [31:0] heading;
  modport source (output valid, pose_x, pose_y, heading, input ready);
  modport sink (input valid, pose_x, pose_y, heading, output ready);
endinterface

FILE: rtl/core/three_wheel_dead_reckoning_top.sv
// Three-wheel dead reckoning. Each input word carries the left, right and front
// wheel angles (Q16.16 rad); each accepted word yields one pose word (x, y,
// heading, Q16.16) while tracking_enable is set, and none when it is clear.
// One word is in work at a time. The sequencer steps through load and
// scaling, the bit-serial turn divider, turn and side, the CORDIC loop
// (CORDIC_STEPS iterations, capped at 24), and the products, pose update and
// emit, with one shared multiplier used nine times. The next word is taken
// only once the sequencer is back in idle, and a pose still waiting in the
// output register holds the emit.
// Registers on the APB port at byte 0x0 enable, 0x4 angle_to_distance,
// 0x8 side_wheel_offset, 0xC front_wheel_offset; write them only while the
// block is idle.
module three_wheel_dead_reckoning_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  twdr_in_if.sink     in_s,
  twdr_out_if.source  out_m,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NSTEPS = (CORDIC_STEPS > twdr_pkg::ATAN_LEN) ? twdr_pkg::ATAN_LEN
                                                              : CORDIC_STEPS;

  twdr_pkg::cfg_t    cfg_r;
  twdr_pkg::cmd_t    cmd;
  twdr_pkg::status_t status;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tracking_enable    <= 1'b1;
      cfg_r.angle_to_distance  <= 16'd6554;
      cfg_r.side_wheel_offset  <= 21'd26214;
      cfg_r.front_wheel_offset <= 21'd26214;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[3:2])
        twdr_pkg::REG_ENABLE: cfg_r.tracking_enable    <= cfg_pwdata[0];
        twdr_pkg::REG_A2D:    cfg_r.angle_to_distance  <= cfg_pwdata[15:0];
        twdr_pkg::REG_SIDE:   cfg_r.side_wheel_offset  <= cfg_pwdata[20:0];
        twdr_pkg::REG_FRONT:  cfg_r.front_wheel_offset <= cfg_pwdata[20:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      twdr_pkg::REG_ENABLE: cfg_prdata = {31'd0, cfg_r.tracking_enable};
      twdr_pkg::REG_A2D:    cfg_prdata = {16'd0, cfg_r.angle_to_distance};
      twdr_pkg::REG_SIDE:   cfg_prdata = {11'd0, cfg_r.side_wheel_offset};
      twdr_pkg::REG_FRONT:  cfg_prdata = {11'd0, cfg_r.front_wheel_offset};
      default:              cfg_prdata = '0;
    endcase
  end

  twdr_ctrl #(.NSTEPS(NSTEPS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_s.valid),
    .enable   (cfg_r.tracking_enable),
    .status   (status),
    .in_ready (in_s.ready),
    .cmd      (cmd)
  );

  twdr_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg         (cfg_r),
    .left_angle  (in_s.left_angle),
    .right_angle (in_s.right_angle),
    .front_angle (in_s.front_angle),
    .out_ready   (out_m.ready),
    .out_valid   (out_m.valid),
    .pose_x      (out_m.pose_x),
    .pose_y      (out_m.pose_y),
    .heading     (out_m.heading),
    .status      (status)
  );

endmodule

FILE: rtl/core/twdr_ctrl.sv
module twdr_ctrl #(
  parameter int NSTEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               enable,
  input  twdr_pkg::status_t  status,
  output logic               in_ready,
  output twdr_pkg::cmd_t     cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_MUL_L = 5'd1;
  localparam logic [4:0] S_MUL_R = 5'd2;
  localparam logic [4:0] S_MUL_F = 5'd3;
  localparam logic [4:0] S_DELTA = 5'd4;
  localparam logic [4:0] S_PREP  = 5'd5;
  localparam logic [4:0] S_DIV   = 5'd6;
  localparam logic [4:0] S_TURN  = 5'd7;
  localparam logic [4:0] S_MUL_S = 5'd8;
  localparam logic [4:0] S_SIDE  = 5'd9;
  localparam logic [4:0] S_FOLD  = 5'd10;
  localparam logic [4:0] S_ROT   = 5'd11;
  localparam logic [4:0] S_FLIP  = 5'd12;
  localparam logic [4:0] S_P1    = 5'd13;
  localparam logic [4:0] S_P2    = 5'd14;
  localparam logic [4:0] S_P3    = 5'd15;
  localparam logic [4:0] S_P4    = 5'd16;
  localparam logic [4:0] S_P5    = 5'd17;
  localparam logic [4:0] S_EMIT  = 5'd18;

  localparam logic [5:0] DIV_LAST = 6'(twdr_pkg::DIV_BITS - 1);
  localparam logic [5:0] ROT_LAST = 6'(NSTEPS - 1);

  logic [4:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd.step  = cnt_r[4:0];
    cmd.op    = twdr_pkg::OP_IDLE;
    case (state_r)
      S_IDLE: begin
        // a word taken while disabled is dropped
        if (in_valid && enable) begin
          cmd.op    = twdr_pkg::OP_LOAD;
          state_nxt = S_MUL_L;
        end
      end
      S_MUL_L: begin cmd.op = twdr_pkg::OP_MUL_L; state_nxt = S_MUL_R; end
      S_MUL_R: begin cmd.op = twdr_pkg::OP_MUL_R; state_nxt = S_MUL_F; end
      S_MUL_F: begin cmd.op = twdr_pkg::OP_MUL_F; state_nxt = S_DELTA; end
      S_DELTA: begin cmd.op = twdr_pkg::OP_DELTA; state_nxt = S_PREP; end
      S_PREP: begin
        cmd.op    = twdr_pkg::OP_PREP;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = twdr_pkg::OP_DIV;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == DIV_LAST) state_nxt = S_TURN;
      end
      S_TURN:  begin cmd.op = twdr_pkg::OP_TURN;  state_nxt = S_MUL_S; end
      S_MUL_S: begin cmd.op = twdr_pkg::OP_MUL_S; state_nxt = S_SIDE; end
      S_SIDE:  begin cmd.op = twdr_pkg::OP_SIDE;  state_nxt = S_FOLD; end
      S_FOLD: begin
        cmd.op    = twdr_pkg::OP_FOLD;
        cnt_nxt   = '0;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        cmd.op  = twdr_pkg::OP_ROT;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == ROT_LAST) state_nxt = S_FLIP;
      end
      S_FLIP: begin cmd.op = twdr_pkg::OP_FLIP; state_nxt = S_P1; end
      S_P1:   begin cmd.op = twdr_pkg::OP_P1;   state_nxt = S_P2; end
      S_P2:   begin cmd.op = twdr_pkg::OP_P2;   state_nxt = S_P3; end
      S_P3:   begin cmd.op = twdr_pkg::OP_P3;   state_nxt = S_P4; end
      S_P4:   begin cmd.op = twdr_pkg::OP_P4;   state_nxt = S_P5; end
      S_P5:   begin cmd.op = twdr_pkg::OP_P5;   state_nxt = S_EMIT; end
      S_EMIT: begin
        // hold until the output register has been drained
        if (!status.out_busy) begin
          cmd.op    = twdr_pkg::OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/core/twdr_dp.sv
module twdr_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  twdr_pkg::cmd_t     cmd,
  input  twdr_pkg::cfg_t     cfg,
  input  logic signed [31:0] left_angle,
  input  logic signed [31:0] right_angle,
  input  logic signed [31:0] front_angle,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [31:0] pose_x,
  output logic signed [31:0] pose_y,
  output logic signed [31:0] heading,
  output twdr_pkg::status_t  status
);

  logic signed [31:0] la_r, ra_r, fa_r;
  logic signed [69:0] prod_r, acc_r;
  logic signed [31:0] ld_r, rd_r;
  logic signed [31:0] pl_r, pr_r, pf_r;
  logic signed [31:0] dl_r, dr_r, df_r;
  logic signed [31:0] fwd_r, turn_r, side_r;
  logic        [48:0] quo_r;
  logic        [21:0] rem_r, den_r;
  logic               nneg_r, flip_r;
  logic signed [31:0] wx_r, wy_r, head_r;
  logic signed [33:0] x_r, y_r, z_r;
  logic               out_valid_r;
  logic signed [31:0] ox_r, oy_r, oh_r;

  logic signed [34:0] mul_a, mul_b;
  logic signed [69:0] mul_p;

  // shared multiplier, operands chosen by the command
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      twdr_pkg::OP_MUL_L: begin
        mul_a = 35'(la_r);
        mul_b = $signed({19'd0, cfg.angle_to_distance});
      end
      twdr_pkg::OP_MUL_R: begin
        mul_a = 35'(ra_r);
        mul_b = $signed({19'd0, cfg.angle_to_distance});
      end
      twdr_pkg::OP_MUL_F: begin
        mul_a = 35'(fa_r);
        mul_b = $signed({19'd0, cfg.angle_to_distance});
      end
      twdr_pkg::OP_MUL_S: begin
        mul_a = 35'(turn_r);
        mul_b = $signed({14'd0, cfg.front_wheel_offset});
      end
      twdr_pkg::OP_SIDE: begin
        mul_a = 35'(head_r);
        mul_b = twdr_pkg::RAD_TO_BAM;
      end
      twdr_pkg::OP_P1: begin mul_a = 35'(fwd_r);  mul_b = 35'(x_r); end
      twdr_pkg::OP_P2: begin mul_a = 35'(side_r); mul_b = 35'(y_r); end
      twdr_pkg::OP_P3: begin mul_a = 35'(fwd_r);  mul_b = 35'(y_r); end
      twdr_pkg::OP_P4: begin mul_a = 35'(side_r); mul_b = 35'(x_r); end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  logic signed [31:0] dist_p, fd;
  logic signed [32:0] sum33, diff33;
  logic        [32:0] mag33;
  logic        [20:0] xo;
  logic        [22:0] shifted;
  logic        [23:0] trial;
  logic               qbig;
  logic signed [31:0] turn_v;
  logic signed [38:0] side_w;
  logic signed [31:0] side_v;
  logic signed [31:0] z32, zf;
  logic               fold;
  logic signed [33:0] xs, ys, atan_v;
  logic signed [69:0] sum_x, sum_y;

  always_comb begin
    dist_p  = prod_r[47:16];
    fd      = -dist_p;
    sum33   = 33'(dl_r) + 33'(dr_r);
    diff33  = 33'(dr_r) - 33'(dl_r);
    mag33   = diff33[32] ? 33'(-diff33) : 33'(diff33);
    xo      = (cfg.side_wheel_offset == '0) ? 21'd1 : cfg.side_wheel_offset;
    shifted = {rem_r, quo_r[48]};
    trial   = {1'b0, shifted} - {2'b00, den_r};
    qbig    = |quo_r[48:31];
    // turn is the negated truncated quotient, saturated
    if (nneg_r) turn_v = qbig ? 32'sh7fffffff : $signed(quo_r[31:0]);
    else        turn_v = qbig ? 32'sh80000000 : -$signed(quo_r[31:0]);
    side_w  = 39'(df_r) - 39'($signed(prod_r[53:16]));
    if (side_w > 39'sh007fffffff)       side_v = 32'sh7fffffff;
    else if (side_w < -39'sh0080000000) side_v = 32'sh80000000;
    else                                side_v = side_w[31:0];
    z32     = prod_r[47:16];
    fold    = (z32 > 32'sh40000000) || (z32 < -32'sh40000000);
    zf      = fold ? (z32 + 32'sh80000000) : z32;
    xs      = x_r >>> cmd.step;
    ys      = y_r >>> cmd.step;
    atan_v  = $signed({2'b00, twdr_pkg::atan_bam(cmd.step)});
    sum_x   = acc_r - prod_r;
    sum_y   = acc_r + prod_r;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      twdr_pkg::OP_LOAD: begin
        la_r <= left_angle;
        ra_r <= right_angle;
        fa_r <= front_angle;
      end
      twdr_pkg::OP_MUL_L: prod_r <= mul_p;
      twdr_pkg::OP_MUL_R: begin prod_r <= mul_p; ld_r <= -dist_p; end
      twdr_pkg::OP_MUL_F: begin prod_r <= mul_p; rd_r <= dist_p; end
      twdr_pkg::OP_DELTA: begin
        dl_r <= ld_r - pl_r;
        dr_r <= rd_r - pr_r;
        df_r <= fd - pf_r;
      end
      twdr_pkg::OP_PREP: begin
        fwd_r  <= sum33[32:1];
        nneg_r <= diff33[32];
        quo_r  <= {mag33, 16'd0};
        rem_r  <= '0;
        den_r  <= {xo, 1'b0};
      end
      twdr_pkg::OP_DIV: begin
        if (!trial[23]) begin
          rem_r <= trial[21:0];
          quo_r <= {quo_r[47:0], 1'b1};
        end else begin
          rem_r <= shifted[21:0];
          quo_r <= {quo_r[47:0], 1'b0};
        end
      end
      twdr_pkg::OP_TURN:  turn_r <= turn_v;
      twdr_pkg::OP_MUL_S: prod_r <= mul_p;
      twdr_pkg::OP_SIDE: begin side_r <= side_v; prod_r <= mul_p; end
      twdr_pkg::OP_FOLD: begin
        z_r    <= 34'(zf);
        flip_r <= fold;
        x_r    <= twdr_pkg::CORDIC_GAIN;
        y_r    <= '0;
      end
      twdr_pkg::OP_ROT: begin
        if (!z_r[33]) begin
          x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - atan_v;
        end else begin
          x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + atan_v;
        end
      end
      twdr_pkg::OP_FLIP: begin
        if (flip_r) begin x_r <= -x_r; y_r <= -y_r; end
      end
      twdr_pkg::OP_P1: prod_r <= mul_p;
      twdr_pkg::OP_P2: begin acc_r <= prod_r; prod_r <= mul_p; end
      twdr_pkg::OP_P3: prod_r <= mul_p;
      twdr_pkg::OP_P4: begin acc_r <= prod_r; prod_r <= mul_p; end
      twdr_pkg::OP_EMIT: begin
        ox_r <= wx_r;
        oy_r <= wy_r;
        oh_r <= head_r;
      end
      default: ;
    endcase
  end

  // pose state and the previous distances reset to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pl_r <= '0; pr_r <= '0; pf_r <= '0;
      wx_r <= '0; wy_r <= '0; head_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == twdr_pkg::OP_DELTA) begin
        pl_r <= ld_r; pr_r <= rd_r; pf_r <= fd;
      end
      if (cmd.op == twdr_pkg::OP_MUL_S) head_r <= head_r + turn_r;
      if (cmd.op == twdr_pkg::OP_P3)    wx_r <= wx_r + sum_x[61:30];
      if (cmd.op == twdr_pkg::OP_P5)    wy_r <= wy_r + sum_y[61:30];
      if (cmd.op == twdr_pkg::OP_EMIT)  out_valid_r <= 1'b1;
      else if (out_ready)               out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign pose_x          = ox_r;
  assign pose_y          = oy_r;
  assign heading         = oh_r;
  assign status.out_busy = out_valid_r;

endmodule

FILE: test/tb_three_wheel_dead_reckoning_top.sv
`timescale 1ns / 100ps

module tb_three_wheel_dead_reckoning_top;

  localparam int STEPS      = 16;
  localparam int SETTLE     = 120;   // outlasts one word in work at the largest CORDIC step count
  localparam int STALL_MAX  = 20000;
  localparam longint GAIN_Q30 = 652032874;

  localparam longint ATAN_TBL [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] hd;
  } pose_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  twdr_in_if  in_ch ();
  twdr_out_if out_ch ();

  three_wheel_dead_reckoning_top #(.CORDIC_STEPS(STEPS)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_s        (in_ch),
    .out_m       (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // predictor state
  twdr_pkg::cfg_t odo_cfg;
  logic [31:0] last_l, last_r, last_f;
  logic [31:0] pos_x, pos_y, yaw;

  pose_t pose_expect [$];
  int    fails;
  int    hold_cycles;
  bit    steady;
  int    quiet_cycles;
  logic [31:0] wl, wr, wf;   // current wheel angles for drifting stimulus

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint sx(input logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [31:0] wheel_dist(input logic [31:0] ang, input bit neg);
    longint d;
    d = (sx(ang) * longint'(odo_cfg.angle_to_distance)) >>> 16;
    if (neg) d = -d;
    return d[31:0];
  endfunction

  task automatic heading_sincos(input logic [31:0] hd, output longint c, output longint s);
    longint prod, z, x, y, xs, ys;
    bit     flip;
    int     n;
    prod = sx(hd) * twdr_pkg::RAD_TO_BAM;
    z = sx(prod[47:16]);
    flip = 1'b0;
    x = GAIN_Q30;
    y = 0;
    n = (STEPS > 24) ? 24 : STEPS;
    if (z > (64'sd1 <<< 30) || z < -(64'sd1 <<< 30)) begin
      z = z + 64'sh80000000;
      z = sx(z[31:0]);
      flip = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - ATAN_TBL[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ATAN_TBL[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = x;
    s = y;
  endtask

  task automatic advance_pose(input logic [31:0] la, input logic [31:0] ra,
                              input logic [31:0] fa);
    logic [31:0] l, r, f;
    longint dl, dr, df, fwd, xo, turn, side, c, s, dx, dy;
    pose_t p;
    if (!odo_cfg.tracking_enable) return;
    l = wheel_dist(la, 1'b1);
    r = wheel_dist(ra, 1'b0);
    f = wheel_dist(fa, 1'b1);
    dl = sx(l - last_l);
    dr = sx(r - last_r);
    df = sx(f - last_f);
    last_l = l; last_r = r; last_f = f;
    fwd = (dl + dr) >>> 1;
    xo = (odo_cfg.side_wheel_offset == 0) ? 1 : longint'(odo_cfg.side_wheel_offset);
    turn = sat32(-(((dr - dl) * 65536) / (2 * xo)));
    side = sat32(df - ((longint'(odo_cfg.front_wheel_offset) * turn) >>> 16));
    yaw = yaw + turn[31:0];
    heading_sincos(yaw, c, s);
    dx = (fwd * c - side * s) >>> 30;
    dy = (fwd * s + side * c) >>> 30;
    pos_x = pos_x + dx[31:0];
    pos_y = pos_y + dy[31:0];
    p.x = pos_x; p.y = pos_y; p.hd = yaw;
    pose_expect = {pose_expect, p};
  endtask

  // input monitor feeds the predictor
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      advance_pose(in_ch.left_angle, in_ch.right_angle, in_ch.front_angle);
  end

  // pose checker
  always @(posedge clk) begin
    pose_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pose_expect.size() == 0) begin
        $error("unexpected pose word: x %0d y %0d heading %0d",
               out_ch.pose_x, out_ch.pose_y, out_ch.heading);
        fails++;
      end else begin
        e = pose_expect.pop_front();
        if (out_ch.pose_x !== e.x) begin
          $error("pose_x mismatch: expected %0d, got %0d", signed'(e.x), out_ch.pose_x);
          fails++;
        end
        if (out_ch.pose_y !== e.y) begin
          $error("pose_y mismatch: expected %0d, got %0d", signed'(e.y), out_ch.pose_y);
          fails++;
        end
        if (out_ch.heading !== e.hd) begin
          $error("heading mismatch: expected %0d, got %0d", signed'(e.hd), out_ch.heading);
          fails++;
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off counted here
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 10);
    end
  end

  // watchdog on cycles with no traffic
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      twdr_pkg::REG_ENABLE: odo_cfg.tracking_enable    = val[0];
      twdr_pkg::REG_A2D:    odo_cfg.angle_to_distance  = val[15:0];
      twdr_pkg::REG_SIDE:   odo_cfg.side_wheel_offset  = val[20:0];
      twdr_pkg::REG_FRONT:  odo_cfg.front_wheel_offset = val[20:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_geometry(input logic [15:0] a2d, input logic [20:0] side_off,
                              input logic [20:0] front_off);
    cfg_write(twdr_pkg::REG_A2D, 32'(a2d));
    cfg_write(twdr_pkg::REG_SIDE, 32'(side_off));
    cfg_write(twdr_pkg::REG_FRONT, 32'(front_off));
  endtask

  // one word on the input channel, at times (never when steady) with a random gap ahead of it
  task automatic send_word(input logic [31:0] la, input logic [31:0] ra,
                           input logic [31:0] fa);
    @(negedge clk);
    if (!steady && $urandom_range(0, 99) < 10) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.left_angle  <= la;
    in_ch.right_angle <= ra;
    in_ch.front_angle <= fa;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    stop_sending();
    while (pose_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_drift(input bit noisy);
    if (noisy) begin
      wl = $urandom(); wr = $urandom(); wf = $urandom();
    end else begin
      wl = wl + 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      wr = wr + 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      wf = wf + 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
    end
    send_word(wl, wr, wf);
  endtask

  task automatic test_field_extremes();
    send_word(32'h0, 32'h0, 32'h0);
    send_word(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_word(32'h80000000, 32'h80000000, 32'h80000000);
    send_word(32'h7fffffff, 32'h80000000, 32'h0);
    send_word(32'h80000000, 32'h7fffffff, 32'hffffffff);
    send_word(32'hffffffff, 32'h00000001, 32'h80000000);
    send_word(32'h00010000, 32'h00020000, 32'h00008000);
    drain();
  endtask

  task automatic test_saturation_and_wrap();
    // zero side offset acts as one: huge turn, saturated side value, fast yaw wrap
    set_geometry(16'hffff, 21'd0, 21'd1048576);
    send_word(32'h7fffffff, 32'h80000000, 32'h0);
    send_word(32'h80000000, 32'h7fffffff, 32'h7fffffff);
    send_word(32'h7fffffff, 32'h80000000, 32'h80000000);
    send_word(32'h80000000, 32'h7fffffff, 32'h0);
    drain();
    set_geometry(16'hffff, 21'd1, 21'd0);
    send_word(32'h7fffffff, 32'h80000000, 32'h12345678);
    send_word(32'h80000000, 32'h7fffffff, 32'hedcba987);
    send_word(32'h7fffffff, 32'h80000000, 32'h0);
    drain();
    set_geometry(16'd0, 21'd1048576, 21'd1048576);
    send_word(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    drain();
  endtask

  task automatic test_tracking_off();
    cfg_write(twdr_pkg::REG_ENABLE, 32'd0);
    send_word(32'h11111111, 32'h22222222, 32'h33333333);
    send_word(32'h80000000, 32'h7fffffff, 32'h0);
    drain();
    cfg_write(twdr_pkg::REG_ENABLE, 32'd1);
    set_geometry(16'd6554, 21'd26214, 21'd26214);
    send_word(32'h00030000, 32'h00050000, 32'h00010000);
    drain();
  endtask

  task automatic test_backpressure();
    hold_cycles = 600;
    for (int i = 0; i < 8; i++) send_drift(1'b0);
    drain();   // sender pauses until every pose word is back
    steady = 1'b1;
    for (int i = 0; i < 12; i++) send_drift(1'b0);
    drain();
    steady = 1'b0;
  endtask

  task automatic test_random();
    logic [15:0] a2d;
    logic [20:0] so, fo;
    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 4))
        0: a2d = 16'hffff;
        1: a2d = 16'd0;
        default: a2d = 16'($urandom());
      endcase
      case ($urandom_range(0, 4))
        0: so = 21'd1;
        1: so = 21'd1048576;
        default: so = 21'($urandom_range(1, 1048576));
      endcase
      case ($urandom_range(0, 4))
        0: fo = 21'd0;
        1: fo = 21'd1048576;
        default: fo = 21'($urandom_range(0, 1048576));
      endcase
      set_geometry(a2d, so, fo);
      if ($urandom_range(0, 7) == 0) begin
        cfg_write(twdr_pkg::REG_ENABLE, 32'd0);
        for (int i = 0; i < 8; i++) send_drift($urandom_range(0, 1));
        drain();
        cfg_write(twdr_pkg::REG_ENABLE, 32'd1);
      end
      for (int i = 0; i < 85; i++) send_drift($urandom_range(0, 99) < 15);
      drain();
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.left_angle = '0;
    in_ch.right_angle = '0;
    in_ch.front_angle = '0;
    out_ch.ready = 1'b0;
    fails = 0;
    hold_cycles = 0;
    steady = 1'b0;
    quiet_cycles = 0;
    wl = '0; wr = '0; wf = '0;
    odo_cfg.tracking_enable    = 1'b1;
    odo_cfg.angle_to_distance  = 16'd6554;
    odo_cfg.side_wheel_offset  = 21'd26214;
    odo_cfg.front_wheel_offset = 21'd26214;
    last_l = '0; last_r = '0; last_f = '0;
    pos_x = '0; pos_y = '0; yaw = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_saturation_and_wrap();
    test_tracking_off();
    test_backpressure();
    test_random();

    if (fails == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
